// ----- sv/bpms_pkg.sv -----
// Shared types and constants for the button press mode selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpms_pkg;

    // Defaults for the top-level parameters
    localparam int DEBOUNCE_TICKS_DEF = 25;
    localparam int PULSE_TICKS_DEF    = 250;
    localparam int MAX_MODES_DEF      = 8;

    // Configuration register indexes
    localparam logic [2:0] REG_BTN_ACTIVE_HIGH = 3'd0;
    localparam logic [2:0] REG_LED_INVERTED    = 3'd1;
    localparam logic [2:0] REG_MODE_COUNT      = 3'd2;
    localparam logic [2:0] REG_MODE_PATTERN    = 3'd3;
    localparam logic [2:0] REG_LED_COLOUR      = 3'd4;
    localparam logic [2:0] REG_START_MODE      = 3'd5;
    localparam logic [2:0] REG_SHORT_HOLD      = 3'd6;
    localparam logic [2:0] REG_CYCLE_TICKS     = 3'd7;

    // Register reset values
    localparam logic [3:0]  MODE_COUNT_RST  = 4'd4;
    localparam logic [11:0] SHORT_HOLD_RST  = 12'd500;
    localparam logic [11:0] CYCLE_TICKS_RST = 12'd1000;

    localparam logic [11:0] ELAPSED_MAX = 12'hFFF;

    typedef struct packed {
        logic        btn_active_high;
        logic        led_inverted;
        logic [3:0]  mode_count;
        logic [63:0] mode_pattern_table;
        logic [23:0] led_colour_table;
        logic [2:0]  start_mode;
        logic [11:0] short_hold_ticks;
        logic [11:0] cycle_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] mode_pins;
        logic [2:0] led_rgb;
        logic       console_reset_pin;
        logic       save_request;
        logic [2:0] save_value;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/bpms_cfg.sv -----
// Configuration register file of the mode selector.
// Depends on bpms_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module bpms_cfg
    import bpms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire logic [2:0]  i_index,
    input  wire logic [63:0] i_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.btn_active_high    <= 1'b0;
            r_cfg.led_inverted       <= 1'b0;
            r_cfg.mode_count         <= MODE_COUNT_RST;
            r_cfg.mode_pattern_table <= '0;
            r_cfg.led_colour_table   <= '0;
            r_cfg.start_mode         <= '0;
            r_cfg.short_hold_ticks   <= SHORT_HOLD_RST;
            r_cfg.cycle_ticks        <= CYCLE_TICKS_RST;
        end else if (i_wr) begin
            unique case (i_index)
                REG_BTN_ACTIVE_HIGH: r_cfg.btn_active_high    <= i_data[0];
                REG_LED_INVERTED:    r_cfg.led_inverted       <= i_data[0];
                REG_MODE_COUNT:      r_cfg.mode_count         <= i_data[3:0];
                REG_MODE_PATTERN:    r_cfg.mode_pattern_table <= i_data;
                REG_LED_COLOUR:      r_cfg.led_colour_table   <= i_data[23:0];
                REG_START_MODE:      r_cfg.start_mode         <= i_data[2:0];
                REG_SHORT_HOLD:      r_cfg.short_hold_ticks   <= i_data[11:0];
                REG_CYCLE_TICKS:     r_cfg.cycle_ticks        <= i_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/bpms_step.sv -----
// Press state machine and result logic: one tick per advance.
// Depends on bpms_pkg for t_cfg, t_result and ELAPSED_MAX.
`default_nettype none

module bpms_step
    import bpms_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEF,
    parameter int PULSE_TICKS    = PULSE_TICKS_DEF,
    parameter int MAX_MODES      = MAX_MODES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_advance,
    input  wire logic i_level,
    input  wire t_cfg i_cfg,
    output t_result   o_result
);

    localparam logic [2:0] PH_STARTUP  = 3'd0;
    localparam logic [2:0] PH_IDLE     = 3'd1;
    localparam logic [2:0] PH_DEBOUNCE = 3'd2;
    localparam logic [2:0] PH_SHORT    = 3'd3;
    localparam logic [2:0] PH_CYCLE    = 3'd4;
    localparam logic [2:0] PH_PULSE    = 3'd5;

    localparam logic [11:0] DEBOUNCE_LIM = 12'(DEBOUNCE_TICKS);
    localparam logic [11:0] PULSE_LIM    = 12'(PULSE_TICKS);
    localparam logic [3:0]  MODES_LIM    = 4'(MAX_MODES);

    logic [2:0]  r_phase,   n_phase;
    logic [11:0] r_elapsed, n_elapsed;
    logic [2:0]  r_active,  n_active;
    logic [2:0]  r_shown,   n_shown;

    logic        pressed;
    logic        pulse;
    logic        save;
    logic [3:0]  count;
    logic [11:0] elapsed_up;
    logic [3:0]  shown_nx;
    logic [7:0]  pin_mask;
    logic [2:0]  colour;

    // Modes in use, clamped to 1..MAX_MODES
    always_comb begin
        count = i_cfg.mode_count;
        if (count == 4'd0) begin
            count = 4'd1;
        end
        if (count > MODES_LIM) begin
            count = MODES_LIM;
        end
    end

    assign pressed    = i_cfg.btn_active_high ? i_level : !i_level;
    assign elapsed_up = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 12'd1 : ELAPSED_MAX;
    assign shown_nx   = {1'b0, r_shown} + 4'd1;

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_active  = r_active;
        n_shown   = r_shown;
        pulse     = 1'b0;
        save      = 1'b0;
        unique case (r_phase)
            PH_STARTUP: begin
                // Saved mode out of range falls back to mode zero
                n_active  = ({1'b0, i_cfg.start_mode} >= count) ? 3'd0 : i_cfg.start_mode;
                n_shown   = n_active;
                save      = 1'b1;
                pulse     = 1'b1;
                n_elapsed = 12'd1;
                n_phase   = PH_PULSE;
            end
            PH_PULSE: begin
                if (r_elapsed >= PULSE_LIM) begin
                    n_phase   = PH_IDLE;
                    n_elapsed = '0;
                end else begin
                    pulse     = 1'b1;
                    n_elapsed = elapsed_up;
                end
            end
            PH_DEBOUNCE: begin
                if (r_elapsed < DEBOUNCE_LIM) begin
                    n_elapsed = elapsed_up;
                end else if (pressed) begin
                    n_phase = PH_SHORT;
                end else begin
                    n_phase   = PH_IDLE;
                    n_elapsed = '0;
                end
            end
            PH_SHORT: begin
                if (!pressed) begin
                    pulse     = 1'b1;
                    n_elapsed = 12'd1;
                    n_phase   = PH_PULSE;
                end else begin
                    n_elapsed = elapsed_up;
                    if (elapsed_up >= i_cfg.short_hold_ticks) begin
                        n_phase = PH_CYCLE;
                    end
                end
            end
            PH_CYCLE: begin
                if (!pressed) begin
                    if (r_active != r_shown) begin
                        n_active = r_shown;
                        save     = 1'b1;
                    end
                    n_phase   = PH_IDLE;
                    n_elapsed = '0;
                end else if (elapsed_up >= i_cfg.cycle_ticks) begin
                    // Step the shown mode, wrap at the mode count
                    n_shown   = (shown_nx >= count) ? 3'd0 : shown_nx[2:0];
                    n_elapsed = '0;
                end else begin
                    n_elapsed = elapsed_up;
                end
            end
            default: begin
                if (pressed) begin
                    n_phase   = PH_DEBOUNCE;
                    n_elapsed = 12'd1;
                end else begin
                    n_phase   = PH_IDLE;
                    n_elapsed = '0;
                end
            end
        endcase
    end

    // OR of the patterns of all modes in use
    always_comb begin
        pin_mask = '0;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < count) begin
                pin_mask = pin_mask | i_cfg.mode_pattern_table[k*8 +: 8];
            end
        end
    end

    assign colour = i_cfg.led_colour_table[n_shown*3 +: 3];

    always_comb begin
        o_result.mode_pins         = i_cfg.mode_pattern_table[n_active*8 +: 8] & pin_mask;
        o_result.led_rgb           = i_cfg.led_inverted ? ~colour : colour;
        o_result.console_reset_pin = pulse ? i_cfg.btn_active_high
                                           : !i_cfg.btn_active_high;
        o_result.save_request      = save;
        o_result.save_value        = save ? n_active : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_STARTUP;
            r_elapsed <= '0;
            r_active  <= '0;
            r_shown   <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_active  <= n_active;
            r_shown   <= n_shown;
        end
    end

endmodule

`default_nettype wire

// ----- sv/button_press_mode_selector.sv -----
// Button press mode selector: one button tick item in, one result item out.
// Result path: the item passes the input register, then the result register.
// Throughput: one item per cycle when not stalled; the press state machine updates once per tick.
// Input stalls only while the input register holds an item and a result waits stalled.
// Reset (i_rst_n low, synchronous): registers to their defaults, startup phase, pipeline empty.
// Depends on bpms_pkg, bpms_cfg and bpms_step.
`default_nettype none

module button_press_mode_selector
    import bpms_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEF,
    parameter int PULSE_TICKS    = PULSE_TICKS_DEF,
    parameter int MAX_MODES      = MAX_MODES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_button_level,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_mode_pins,
    output logic [2:0]       o_led_rgb,
    output logic             o_console_reset_pin,
    output logic             o_save_request,
    output logic [2:0]       o_save_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    bpms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register: hold the item while the result side is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_level <= i_button_level;
        end
    end

    bpms_step #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
        .PULSE_TICKS    (PULSE_TICKS),
        .MAX_MODES      (MAX_MODES)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_level   (r_in_level),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mode_pins         = r_out.mode_pins;
    assign o_led_rgb           = r_out.led_rgb;
    assign o_console_reset_pin = r_out.console_reset_pin;
    assign o_save_request      = r_out.save_request;
    assign o_save_value        = r_out.save_value;

endmodule

`default_nettype wire
